// ----- sv/cfq_pkg.sv -----
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types, constants and helper functions for the circular FIFO queue.
// ----------------------------------------------------------------------------
package cfq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH);
	localparam int WORD_W = 32;
	localparam int OCC_W  = 4;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_ROTATE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNDERFLOW = 2'd2
	} err_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Advance a pointer by one, wrapping at the end of the ring.
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

// ----- sv/cfq_ram.sv -----
// ----------------------------------------------------------------------------
// cfq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/circular_fifo_queue.sv -----
// ----------------------------------------------------------------------------
// circular_fifo_queue
// Ring-buffer FIFO with push, pop, peek and rotate commands.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low.
// Every transaction produces exactly one result, shown on the result ports for
// a single cycle with done high, registered from the execute state; the
// receiver cannot stall it. Transactions do not overlap in the block:
// the accepting cycle reads the head word from the storage RAM, whose read
// data is registered, and the following cycle (busy high) uses that word,
// writes back to the RAM and updates the pointers and the count. The result
// register then holds the answer while the next transaction is accepted.
// The queue is full at DEPTH-1 words; one slot is always left free.
module circular_fifo_queue
	import cfq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            func,
	input  logic [WORD_W-1:0]     push_data,
	output logic                  done,
	output logic [WORD_W-1:0]     head_data,
	output logic [1:0]            error_code,
	output logic [OCC_W-1:0]      occupancy,
	output logic                  is_empty,
	output logic                  is_full
);

	state_t state_q, state_n;

	// Queue bookkeeping. The words themselves live in the RAM.
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_n, tail_n;
	logic [CNT_W-1:0] count_n;

	// Command captured at acceptance.
	op_t                   op_q;
	logic [DATA_WIDTH-1:0] word_q;

	// Result register.
	logic                  done_q;
	logic [WORD_W-1:0]     head_data_q;
	err_t                  err_q;
	logic [OCC_W-1:0]      occ_q;
	logic                  empty_q, full_q;

	logic                  accept;
	logic                  rd_en;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  wr_en;
	logic [PTR_W-1:0]      wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [WORD_W-1:0]     result;
	err_t                  err;
	logic                  q_full;
	logic                  q_empty;
	logic                  exec;

	assign accept = start && !busy;

	// Next-state logic: each transaction passes through the execute state once.
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// State machine outputs.
	always_comb begin
		busy  = 1'b0;
		exec  = 1'b0;
		rd_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_en = start;
			end
			ST_EXEC: begin
				busy = 1'b1;
				exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// The head word is fetched speculatively for every transaction; only pop,
	// peek and rotate use it. Writes happen only in the execute cycle, while no
	// read is issued, so the RAM never sees a read and a write to overlap.
	cfq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (head_q),
		.rdata (rd_data)
	);

	assign q_full  = (count_q == CNT_W'(DEPTH - 1));
	assign q_empty = (count_q == '0);

	// Execute the captured command against the head word from the RAM.
	always_comb begin
		head_n  = head_q;
		tail_n  = tail_q;
		count_n = count_q;
		wr_en   = 1'b0;
		wr_addr = next_ptr(tail_q);
		wr_data = word_q;
		result  = '0;
		err     = ERR_NONE;
		case (op_q)
			OP_PUSH: begin
				if (q_full) begin
					err = ERR_OVERFLOW;
				end else begin
					wr_en   = exec;
					tail_n  = next_ptr(tail_q);
					count_n = count_q + CNT_W'(1);
				end
			end
			OP_POP: begin
				if (q_empty) begin
					err = ERR_UNDERFLOW;
				end else begin
					result  = WORD_W'(rd_data);
					head_n  = next_ptr(head_q);
					count_n = count_q - CNT_W'(1);
				end
			end
			OP_PEEK: begin
				if (q_empty) begin
					err = ERR_UNDERFLOW;
				end else begin
					result = WORD_W'(rd_data);
				end
			end
			OP_ROTATE: begin
				// The old head word is copied to the slot after the tail.
				if (q_empty) begin
					err = ERR_UNDERFLOW;
				end else begin
					wr_en   = exec;
					wr_data = rd_data;
					head_n  = next_ptr(head_q);
					tail_n  = next_ptr(tail_q);
				end
			end
			default: begin
				err = ERR_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= PTR_W'(DEPTH - 1);
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= exec;
			if (exec) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				count_q <= count_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(func);
			word_q <= DATA_WIDTH'(push_data);
		end
		if (exec) begin
			head_data_q <= result;
			err_q       <= err;
			occ_q       <= OCC_W'(count_n);
			empty_q     <= (count_n == '0);
			full_q      <= (count_n == CNT_W'(DEPTH - 1));
		end
	end

	assign done       = done_q;
	assign head_data  = head_data_q;
	assign error_code = err_q;
	assign occupancy  = occ_q;
	assign is_empty   = empty_q;
	assign is_full    = full_q;

endmodule

// ----- sv/cfq_checker.sv -----
// ----------------------------------------------------------------------------
// cfq_checker
// Port-level checks for the circular FIFO queue, bound to the top level.
// ----------------------------------------------------------------------------
module cfq_checker
	import cfq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [WORD_W-1:0] head_data,
	input logic [1:0]        error_code,
	input logic [OCC_W-1:0]  occupancy,
	input logic              is_empty,
	input logic              is_full
);

	// Every accepted transaction yields its result strobe.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("transaction accepted without a result two cycles later");

	// An overflow is only reported by a full queue.
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && error_code == ERR_OVERFLOW |-> is_full && !is_empty)
		else $error("overflow reported while the queue is not full");

	// An underflow is only reported by an empty queue.
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && error_code == ERR_UNDERFLOW |-> is_empty && occupancy == '0)
		else $error("underflow reported while the queue holds words");

	// A failed transaction never returns a word.
	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && error_code != ERR_NONE |-> head_data == '0)
		else $error("head word returned on a failed transaction");

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (.*);

// ----- test/tb_circular_fifo_queue.sv -----
// ----------------------------------------------------------------------------
// tb_circular_fifo_queue
// Self-checking testbench for the ring-buffer FIFO with push, pop, peek and
// rotate commands. A mirror of the queue predicts every result, and each
// result strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

// Expected contents of one result strobe.
typedef struct {
	logic [cfq_pkg::WORD_W-1:0] head_data;
	cfq_pkg::err_t              error_code;
	logic [cfq_pkg::OCC_W-1:0]  occupancy;
	logic                       is_empty;
	logic                       is_full;
} fifo_result_t;

// Mirror of the queue contents plus the results it predicts, in order.
class fifo_tracker;
	logic [cfq_pkg::WORD_W-1:0] slots [cfq_pkg::DEPTH];
	int unsigned                head_ptr;
	int unsigned                tail_ptr;
	int unsigned                fill;
	fifo_result_t               pending [$];
	int unsigned                fail_count;

	function new();
		head_ptr   = 0;
		tail_ptr   = cfq_pkg::DEPTH - 1;
		fill       = 0;
		fail_count = 0;
	endfunction

	// Applies one accepted command to the mirror and queues its result.
	function void note_command(cfq_pkg::op_t op, logic [cfq_pkg::WORD_W-1:0] word);
		fifo_result_t r;
		r.head_data  = '0;
		r.error_code = cfq_pkg::ERR_NONE;
		if (op == cfq_pkg::OP_PUSH) begin
			if (fill == cfq_pkg::DEPTH - 1) begin
				r.error_code = cfq_pkg::ERR_OVERFLOW;
			end else begin
				tail_ptr        = (tail_ptr + 1) % cfq_pkg::DEPTH;
				slots[tail_ptr] = word;
				fill++;
			end
		end else if (fill == 0) begin
			r.error_code = cfq_pkg::ERR_UNDERFLOW;
		end else if (op == cfq_pkg::OP_POP) begin
			r.head_data = slots[head_ptr];
			head_ptr    = (head_ptr + 1) % cfq_pkg::DEPTH;
			fill--;
		end else if (op == cfq_pkg::OP_PEEK) begin
			r.head_data = slots[head_ptr];
		end else begin
			// Rotate: the head word is copied one past the tail.
			tail_ptr        = (tail_ptr + 1) % cfq_pkg::DEPTH;
			slots[tail_ptr] = slots[head_ptr];
			head_ptr        = (head_ptr + 1) % cfq_pkg::DEPTH;
		end
		r.occupancy = cfq_pkg::OCC_W'(fill);
		r.is_empty  = (fill == 0);
		r.is_full   = (fill == cfq_pkg::DEPTH - 1);
		pending.push_back(r);
	endfunction

	// Compares one result strobe with the oldest prediction.
	function void check_response(logic [cfq_pkg::WORD_W-1:0] head_data,
			logic [1:0] error_code, logic [cfq_pkg::OCC_W-1:0] occupancy,
			logic is_empty, logic is_full);
		fifo_result_t e;
		if (pending.size() == 0) begin
			$error("result strobe with no transaction outstanding");
			fail_count++;
			return;
		end
		e = pending.pop_front();
		if (head_data !== e.head_data) begin
			$error("head_data: expected %h, actual %h", e.head_data, head_data);
			fail_count++;
		end
		if (error_code !== e.error_code) begin
			$error("error_code: expected %0d, actual %0d", e.error_code, error_code);
			fail_count++;
		end
		if (occupancy !== e.occupancy) begin
			$error("occupancy: expected %0d, actual %0d", e.occupancy, occupancy);
			fail_count++;
		end
		if (is_empty !== e.is_empty) begin
			$error("is_empty: expected %b, actual %b", e.is_empty, is_empty);
			fail_count++;
		end
		if (is_full !== e.is_full) begin
			$error("is_full: expected %b, actual %b", e.is_full, is_full);
			fail_count++;
		end
	endfunction
endclass

module tb_circular_fifo_queue;
	import cfq_pkg::*;

	// The limit leaves a wide margin over the length of a correct run.
	localparam int CYCLE_LIMIT  = 40000;
	localparam int RANDOM_ITEMS = 400;
	localparam int IDLE_PCT     = 13;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        func;
	logic [WORD_W-1:0] push_data;
	logic              done;
	logic [WORD_W-1:0] head_data;
	logic [1:0]        error_code;
	logic [OCC_W-1:0]  occupancy;
	logic              is_empty;
	logic              is_full;

	fifo_tracker tracker = new();
	int unsigned cycle_count = 0;
	bit          idle_enable = 1'b1;

	circular_fifo_queue dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.push_data  (push_data),
		.done       (done),
		.head_data  (head_data),
		.error_code (error_code),
		.occupancy  (occupancy),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The watchdog counts rising edges and ends a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Results cannot be held off, so every strobe seen at a rising edge is
	// checked right away. Outputs are read before the edge's own updates land.
	always @(posedge clk) begin
		if (arst_n && done) begin
			tracker.check_response(head_data, error_code, occupancy, is_empty, is_full);
		end
	end

	// Drives one transaction from a falling edge and holds it until the block
	// takes it: the accepting rising edge is the first one with busy low.
	// Afterwards the sender may pause at random, which moves the next
	// transaction onto a different phase of the block's accept rhythm.
	task automatic issue(input op_t op, input logic [WORD_W-1:0] word);
		start     <= 1'b1;
		func      <= op;
		push_data <= word;
		do @(posedge clk); while (busy);
		tracker.note_command(op, word);
		@(negedge clk);
		if (idle_enable && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// Picks an operation with the given chance of a push and of a pop; the
	// rest is split between peek and rotate.
	function automatic op_t pick_op(input int push_pct, input int pop_pct);
		int r;
		r = $urandom_range(99);
		if (r < push_pct) return OP_PUSH;
		if (r < push_pct + pop_pct) return OP_POP;
		return ($urandom_range(1) != 0) ? OP_PEEK : OP_ROTATE;
	endfunction

	initial begin
		int sent;
		int phase;
		int phase_len;
		int push_pct;
		int pop_pct;

		arst_n    = 1'b0;
		start     = 1'b0;
		func      = OP_PUSH;
		push_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. An empty queue must refuse pop, peek and rotate.
		issue(OP_POP, 32'hDEAD_BEEF);
		issue(OP_PEEK, 32'h0);
		issue(OP_ROTATE, 32'hFFFF_FFFF);
		// Extreme words, then peek and a rotate that swaps the two entries.
		issue(OP_PUSH, 32'h0000_0000);
		issue(OP_PUSH, 32'hFFFF_FFFF);
		issue(OP_PEEK, 32'h0);
		issue(OP_ROTATE, 32'h0);
		issue(OP_POP, 32'h0);
		// Fill to the full mark with alternating bit patterns, then overflow.
		for (int i = 0; i < 14; i++) begin
			issue(OP_PUSH, (i % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555);
		end
		issue(OP_PUSH, 32'h1234_5678);

		// Random part. Phases lean toward filling, draining or a balanced mix,
		// so the queue keeps running into both ends and the pointers wrap many
		// times. One long stretch in the middle runs without any sender pauses.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(30, 50);
			case (phase % 3)
				0: begin
					push_pct = 70;
					pop_pct  = 15;
				end
				1: begin
					push_pct = 15;
					pop_pct  = 70;
				end
				default: begin
					push_pct = 35;
					pop_pct  = 35;
				end
			endcase
			for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
				idle_enable = !(sent >= 150 && sent < 260);
				issue(pick_op(push_pct, pop_pct), $urandom);
				sent++;
			end
			phase++;
		end
		start <= 1'b0;

		// Drain: wait for every outstanding result, and wait on after that so
		// a stray strobe would still be caught.
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);

		if (tracker.fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
